// File: rtl/core/tmspg_pkg.sv
// shared constants, types and the period table of the three-motor step generator
`default_nettype none

package tmspg_pkg;

   localparam int COUNT_WIDTH  = 17;
   localparam int PERIOD_WIDTH = 9;
   localparam int MULT_WIDTH   = 8;
   localparam int NUM_MOTORS   = 3;
   localparam int NUM_PATTERNS = 3;
   localparam int TABLE_ROWS   = 3;
   localparam int CURSOR_WIDTH = 3;
   localparam int PATTERN_WIDTH = 2;
   localparam int OP_WIDTH     = 2;
   localparam int BIT_WIDTH    = $clog2(COUNT_WIDTH);

   localparam logic [CURSOR_WIDTH-1:0] MENU_LAST  = CURSOR_WIDTH'(4);
   localparam logic [CURSOR_WIDTH-1:0] MENU_START = CURSOR_WIDTH'(3);
   localparam logic [CURSOR_WIDTH-1:0] MENU_STOP  = CURSOR_WIDTH'(4);

   localparam logic [MULT_WIDTH-1:0] MULT_RESET = MULT_WIDTH'(75);

   localparam logic [OP_WIDTH-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_ENCODER = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_BUTTON  = 2'd2;

   localparam logic [BIT_WIDTH-1:0] TOP_BIT = BIT_WIDTH'(COUNT_WIDTH - 1);

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 16;

   // commands from controller to datapath
   typedef struct packed {
      logic                 apply_event;
      logic                 tick_start;
      logic                 div_step;
      logic [BIT_WIDTH-1:0] div_bit;
      logic                 tick_finish;
      logic                 rsp_load;
   } ctrl_cmd_type;

   // period of one motor in one pattern; zero beyond the table
   function automatic logic [PERIOD_WIDTH-1:0] period_of(
      input logic [PATTERN_WIDTH-1:0] row,
      input logic [1:0]               motor
   );
      logic [PERIOD_WIDTH-1:0] p;
      p = '0;
      case (row)
         2'd0: begin
            case (motor)
               2'd0:    p = PERIOD_WIDTH'(200);
               2'd1:    p = PERIOD_WIDTH'(100);
               2'd2:    p = PERIOD_WIDTH'(150);
               default: p = '0;
            endcase
         end
         2'd1: begin
            case (motor)
               2'd0:    p = PERIOD_WIDTH'(500);
               2'd1:    p = PERIOD_WIDTH'(400);
               2'd2:    p = PERIOD_WIDTH'(300);
               default: p = '0;
            endcase
         end
         2'd2: begin
            case (motor)
               2'd0:    p = PERIOD_WIDTH'(150);
               2'd1:    p = PERIOD_WIDTH'(200);
               2'd2:    p = PERIOD_WIDTH'(400);
               default: p = '0;
            endcase
         end
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/tmspg_ctrl.sv
// controller state machine: sequences tick division, event apply and result handoff
`default_nettype none

module tmspg_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [tmspg_pkg::OP_WIDTH-1:0] req_op,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output tmspg_pkg::ctrl_cmd_type            cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIV    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic [tmspg_pkg::BIT_WIDTH-1:0] bit_ff, bit_in;
   logic                            valid_ff, valid_in;
   logic                            accept;
   logic                            slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   assign slot_free  = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      cmd      = '0;
      cmd.div_bit = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == tmspg_pkg::OP_TICK) begin
                  cmd.tick_start = 1'b1;
                  bit_in   = tmspg_pkg::TOP_BIT;
                  state_in = ST_DIV;
               end else begin
                  cmd.apply_event = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.tick_finish = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.rsp_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_ff   <= bit_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/tmspg_datapath.sv
// datapath: tick count, per-motor remainder lanes, menu state and result register
`default_nettype none

module tmspg_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tmspg_pkg::ctrl_cmd_type               cmd,
   input  wire logic [tmspg_pkg::OP_WIDTH-1:0]        req_op,
   input  wire logic                                  req_cw,
   input  wire logic                                  csr_wr_en,
   input  wire logic [tmspg_pkg::MULT_WIDTH-1:0]      csr_wr_data,
   output logic [tmspg_pkg::RSP_DATA_WIDTH-1:0]       rsp_data
);

   localparam int PW = tmspg_pkg::PERIOD_WIDTH;
   localparam int CW = tmspg_pkg::COUNT_WIDTH;
   localparam int NM = tmspg_pkg::NUM_MOTORS;

   logic [CW-1:0]                           count_ff, count_in;
   logic [CW-1:0]                           end_ff, end_in;
   logic                                    run_ff, run_in;
   logic [NM-1:0]                           step_ff, step_in;
   logic [tmspg_pkg::CURSOR_WIDTH-1:0]      cursor_ff, cursor_in;
   logic [tmspg_pkg::PATTERN_WIDTH-1:0]     pattern_ff, pattern_in;
   logic [tmspg_pkg::MULT_WIDTH-1:0]        mult_ff, mult_in;
   logic [PW-1:0]                           rem_ff [NM];
   logic [PW-1:0]                           rem_in [NM];
   logic [tmspg_pkg::RSP_DATA_WIDTH-1:0]    rsp_ff, rsp_in;

   logic [PW-1:0]  period [NM];
   logic [PW:0]    shifted [NM];
   logic [NM-1:0]  divides;
   logic           found;

   assign rsp_data = rsp_ff;

   always_comb begin
      for (int m = 0; m < NM; m++) begin
         period[m]  = tmspg_pkg::period_of(pattern_ff, 2'(m));
         shifted[m] = {rem_ff[m], count_ff[cmd.div_bit]};
         divides[m] = (period[m] != '0) && (rem_ff[m] == '0);
      end
   end

   always_comb begin
      count_in   = count_ff;
      end_in     = end_ff;
      run_in     = run_ff;
      step_in    = step_ff;
      cursor_in  = cursor_ff;
      pattern_in = pattern_ff;
      mult_in    = mult_ff;
      rsp_in     = rsp_ff;
      found      = 1'b0;
      for (int m = 0; m < NM; m++) begin
         rem_in[m] = rem_ff[m];
      end

      if (csr_wr_en) begin
         mult_in = csr_wr_data;
      end

      // menu events
      if (cmd.apply_event) begin
         case (req_op)
            tmspg_pkg::OP_ENCODER: begin
               if (req_cw) begin
                  cursor_in = (cursor_ff >= tmspg_pkg::MENU_LAST) ? '0 : cursor_ff + 1'b1;
               end else begin
                  cursor_in = (cursor_ff == '0) ? tmspg_pkg::MENU_LAST : cursor_ff - 1'b1;
               end
            end
            tmspg_pkg::OP_BUTTON: begin
               if (cursor_ff == tmspg_pkg::MENU_START) begin
                  run_in = 1'b1;
               end else if (cursor_ff == tmspg_pkg::MENU_STOP) begin
                  run_in = 1'b0;
               end else if (cursor_ff < tmspg_pkg::CURSOR_WIDTH'(tmspg_pkg::NUM_PATTERNS)
                            && cursor_ff < tmspg_pkg::CURSOR_WIDTH'(tmspg_pkg::TABLE_ROWS)) begin
                  pattern_in = cursor_ff[tmspg_pkg::PATTERN_WIDTH-1:0];
               end
            end
            default: ;
         endcase
      end

      // tick: advance count, latch end value, clear remainders
      if (cmd.tick_start) begin
         count_in = count_ff + 1'b1;
         end_in   = CW'(period[NM-1]) * CW'(mult_ff);
         for (int m = 0; m < NM; m++) begin
            rem_in[m] = '0;
         end
      end

      // one restoring division bit per lane
      if (cmd.div_step) begin
         for (int m = 0; m < NM; m++) begin
            if (shifted[m] >= {1'b0, period[m]}) begin
               rem_in[m] = PW'(shifted[m] - {1'b0, period[m]});
            end else begin
               rem_in[m] = shifted[m][PW-1:0];
            end
         end
      end

      if (cmd.tick_finish) begin
         for (int m = 0; m < NM; m++) begin
            if (!found && divides[m]) begin
               found = 1'b1;
               if (run_ff) begin
                  step_in[m] = ~step_ff[m];
               end
            end
         end
         if (count_ff >= end_ff) begin
            count_in = '0;
            run_in   = 1'b0;
         end
      end

      if (cmd.rsp_load) begin
         rsp_in = tmspg_pkg::RSP_DATA_WIDTH'({pattern_ff, cursor_ff, run_ff,
                                              step_ff[2], step_ff[1], step_ff[0]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         run_ff     <= 1'b0;
         step_ff    <= '0;
         cursor_ff  <= '0;
         pattern_ff <= '0;
         mult_ff    <= tmspg_pkg::MULT_RESET;
      end else begin
         count_ff   <= count_in;
         run_ff     <= run_in;
         step_ff    <= step_in;
         cursor_ff  <= cursor_in;
         pattern_ff <= pattern_in;
         mult_ff    <= mult_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      rsp_ff <= rsp_in;
      for (int m = 0; m < NM; m++) begin
         rem_ff[m] <= rem_in[m];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/three_motor_step_pattern_generator_core.sv
// top level of the three-motor step pattern generator with rotary menu
`default_nettype none

// channel   | direction | fields
// ----------+-----------+------------------------------------------------------
// req_      | in        | tuser: op; tdata: turn_clockwise
// rsp_      | out       | tdata: step lines 1..3, motors_running, menu, pattern
// csr_      | in        | run_length_multiplier write, no read-back
//
// a timer tick item runs from accept to result in order: accept advances the count,
// division steps form the bit-serial remainder of the count by each motor period
// (three lanes side by side), finish toggles and checks the end, then the result
// register loads once the slot is free; encoder and button items apply at accept.
// synchronous reset clears all control state and loads multiplier 75.
// one item is worked at a time; a stalled result holds the next item off.

module three_motor_step_pattern_generator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // item in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] turn_clockwise, [7:1] zero
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   // item out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [0] step_line_1, [1] step_line_2,
                                         // [2] step_line_3, [3] motors_running,
                                         // [6:4] menu_position,
                                         // [8:7] active_pattern, [15:9] zero
   // register write
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data  // run_length_multiplier
);

   tmspg_pkg::ctrl_cmd_type cmd;

   // sequencing: accept, division steps, finish, result handoff
   tmspg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // state, remainder lanes and result register
   tmspg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_op      (req_tuser),
      .req_cw      (req_tdata[0]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: tb/tb_three_motor_step_pattern_generator_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the three-motor step pattern generator core
module tb_three_motor_step_pattern_generator_core;

   // op code the block leaves unused: it only reports the current state
   localparam logic [tmspg_pkg::OP_WIDTH-1:0] OP_UNUSED = 2'd3;

   localparam int IDLE_LIMIT    = 4000; // cycles without any handshake
   localparam int SETTLE_CYCLES = 30;   // settle time after the last result
   localparam int PHASE_ITEMS   = 200;

   // pattern periods per motor, rows are patterns
   localparam int unsigned PATTERN_PERIOD [tmspg_pkg::TABLE_ROWS][tmspg_pkg::NUM_MOTORS] = '{
      '{200, 100, 150},
      '{500, 400, 300},
      '{150, 200, 400}
   };

   // status as packed in rsp_tdata[8:0], lowest bit last
   typedef struct packed {
      logic [tmspg_pkg::PATTERN_WIDTH-1:0] active_pattern;
      logic [tmspg_pkg::CURSOR_WIDTH-1:0]  menu_position;
      logic                                motors_running;
      logic                                step_line_3;
      logic                                step_line_2;
      logic                                step_line_1;
   } motor_status_type;

   typedef struct packed {
      logic [tmspg_pkg::OP_WIDTH-1:0] op;
      logic                           turn_cw;
   } motor_event_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;     // [0] turn_clockwise, [7:1] zero
   logic [1:0]  req_tuser   = '0;     // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;            // [2:0] step lines, [3] running,
                                      // [6:4] menu, [8:7] pattern
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;     // run_length_multiplier

   three_motor_step_pattern_generator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor state: a private copy of everything the block holds
   // ---------------------------------------------------------------
   logic [tmspg_pkg::COUNT_WIDTH-1:0]   tick_total    = '0;
   logic                                motors_on     = 1'b0;
   logic [tmspg_pkg::NUM_MOTORS-1:0]    step_level    = '0;
   logic [tmspg_pkg::CURSOR_WIDTH-1:0]  cursor_now    = '0;
   logic [tmspg_pkg::PATTERN_WIDTH-1:0] pattern_now   = '0;
   logic [tmspg_pkg::MULT_WIDTH-1:0]    run_mult      = tmspg_pkg::MULT_RESET;

   motor_event_type  pending_events [$];
   motor_status_type expected_status [$];

   int mismatch_count = 0;
   int idle_cycles    = 0;
   logic req_taken    = 1'b0;

   function automatic int unsigned motor_period(int motor);
      // patterns outside the table have no periods
      if (pattern_now >= tmspg_pkg::TABLE_ROWS) return 0;
      return PATTERN_PERIOD[pattern_now][motor];
   endfunction

   // applies one event to the predictor state and returns the status it shows
   function automatic motor_status_type predict_status(logic [tmspg_pkg::OP_WIDTH-1:0] op,
                                                       logic turn_cw);
      int unsigned      period;
      int unsigned      end_count;
      bit               toggled;
      motor_status_type s;
      toggled = 1'b0;
      case (op)
         tmspg_pkg::OP_TICK: begin
            tick_total = tick_total + 1'b1;   // wraps at the count width
            // first motor in priority order whose period divides the count
            for (int m = 0; m < tmspg_pkg::NUM_MOTORS; m++) begin
               period = motor_period(m);
               if (!toggled && period != 0 && (tick_total % period) == 0) begin
                  toggled = 1'b1;
                  if (motors_on) step_level[m] = ~step_level[m];
               end
            end
            // reaching or passing the end of the run restarts and stops
            end_count = motor_period(tmspg_pkg::NUM_MOTORS - 1) * run_mult;
            if (tick_total >= end_count) begin
               tick_total = '0;
               motors_on  = 1'b0;
            end
         end
         tmspg_pkg::OP_ENCODER: begin
            if (turn_cw) cursor_now = (cursor_now == tmspg_pkg::MENU_LAST) ? '0
                                                                         : cursor_now + 1'b1;
            else         cursor_now = (cursor_now == '0) ? tmspg_pkg::MENU_LAST
                                                         : cursor_now - 1'b1;
         end
         tmspg_pkg::OP_BUTTON: begin
            if (cursor_now == tmspg_pkg::MENU_START)      motors_on = 1'b1;
            else if (cursor_now == tmspg_pkg::MENU_STOP)  motors_on = 1'b0;
            else if (cursor_now < tmspg_pkg::NUM_PATTERNS)
               pattern_now = cursor_now[tmspg_pkg::PATTERN_WIDTH-1:0];
         end
         default: begin
            // unused op: state is only reported
         end
      endcase
      s.step_line_1    = step_level[0];
      s.step_line_2    = step_level[1];
      s.step_line_3    = step_level[2];
      s.motors_running = motors_on;
      s.menu_position  = cursor_now;
      s.active_pattern = pattern_now;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got_v, want_v);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // sender: bursts of items separated by random gaps
   // ---------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      motor_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // item still on offer, hold it
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_tvalid <= 1'b0;
      end else if (pending_events.size() > 0) begin
         ev = pending_events.pop_front();
         req_tuser  <= ev.op;
         req_tdata  <= {7'd0, ev.turn_cw};
         req_tvalid <= 1'b1;
         if (burst_left == 0) burst_left = $urandom_range(1, 16);
         burst_left = burst_left - 1;
         // a quarter of the bursts run straight into the next one
         if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // receiver: stretches of always ready, random stalls and heavy stalls
   // ---------------------------------------------------------------
   int stall_mode      = 0;
   int stall_mode_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(20, 300);
         end
         stall_mode_left = stall_mode_left - 1;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // monitor: checks each result, then predicts each accepted item
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      motor_status_type want;
      motor_status_type got;
      if (reset) begin
         req_taken   <= 1'b0;
         tick_total  = '0;
         motors_on   = 1'b0;
         step_level  = '0;
         cursor_now  = '0;
         pattern_now = '0;
         run_mult    = tmspg_pkg::MULT_RESET;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (csr_wr_en) run_mult = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[8:0];
            if (expected_status.size() == 0) begin
               report_mismatch("result with no item outstanding", rsp_tdata, 0);
            end else begin
               want = expected_status.pop_front();
               if (got.step_line_1 !== want.step_line_1)
                  report_mismatch("step_line_1", got.step_line_1, want.step_line_1);
               if (got.step_line_2 !== want.step_line_2)
                  report_mismatch("step_line_2", got.step_line_2, want.step_line_2);
               if (got.step_line_3 !== want.step_line_3)
                  report_mismatch("step_line_3", got.step_line_3, want.step_line_3);
               if (got.motors_running !== want.motors_running)
                  report_mismatch("motors_running", got.motors_running, want.motors_running);
               if (got.menu_position !== want.menu_position)
                  report_mismatch("menu_position", got.menu_position, want.menu_position);
               if (got.active_pattern !== want.active_pattern)
                  report_mismatch("active_pattern", got.active_pattern, want.active_pattern);
            end
            if (rsp_tdata[15:9] !== '0)
               report_mismatch("rsp_tdata padding", rsp_tdata[15:9], 0);
         end
         if (req_tvalid && req_tready)
            expected_status.push_back(predict_status(req_tuser, req_tdata[0]));
      end
   end

   // watchdog: a run that stops moving is a failure
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   logic [tmspg_pkg::CURSOR_WIDTH-1:0] plan_cursor = '0;  // cursor as the queued items leave it
   int                                 useful_items = 0;  // items that are not ignored

   task automatic queue_event(input logic [tmspg_pkg::OP_WIDTH-1:0] op, input logic turn_cw);
      motor_event_type ev;
      ev.op      = op;
      ev.turn_cw = turn_cw;
      pending_events.push_back(ev);
      if (op != OP_UNUSED) useful_items++;
      if (op == tmspg_pkg::OP_ENCODER) begin
         if (turn_cw) plan_cursor = (plan_cursor == tmspg_pkg::MENU_LAST) ? '0
                                                                         : plan_cursor + 1'b1;
         else         plan_cursor = (plan_cursor == '0) ? tmspg_pkg::MENU_LAST
                                                        : plan_cursor - 1'b1;
      end
   endtask

   // walk the menu to a position, in one random direction
   task automatic queue_menu_walk(input logic [tmspg_pkg::CURSOR_WIDTH-1:0] target);
      logic turn_cw;
      turn_cw = 1'($urandom_range(0, 1));
      while (plan_cursor != target) queue_event(tmspg_pkg::OP_ENCODER, turn_cw);
   endtask

   // mostly well-formed menu sequences and long tick runs, some noise
   task automatic queue_random_events(input int count);
      int start;
      int pick;
      start = useful_items;
      while (useful_items - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            repeat ($urandom_range(1, 60))
               queue_event(tmspg_pkg::OP_TICK, 1'($urandom_range(0, 1)));
         end else if (pick < 72) begin
            queue_menu_walk(tmspg_pkg::CURSOR_WIDTH'($urandom_range(0,
                                                     tmspg_pkg::NUM_PATTERNS - 1)));
            queue_event(tmspg_pkg::OP_BUTTON, 1'($urandom_range(0, 1)));
         end else if (pick < 84) begin
            queue_menu_walk(tmspg_pkg::MENU_START);
            queue_event(tmspg_pkg::OP_BUTTON, 1'($urandom_range(0, 1)));
         end else if (pick < 89) begin
            queue_menu_walk(tmspg_pkg::MENU_STOP);
            queue_event(tmspg_pkg::OP_BUTTON, 1'($urandom_range(0, 1)));
         end else if (pick < 93) begin
            // broken sequence: cursor moves, no press follows
            queue_menu_walk(tmspg_pkg::CURSOR_WIDTH'($urandom_range(0,
                                                     tmspg_pkg::MENU_LAST)));
         end else begin
            repeat ($urandom_range(1, 4))
               queue_event(tmspg_pkg::OP_WIDTH'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
         end
      end
   endtask

   // wait until every item is sent and answered, then let the core settle
   task automatic wait_until_drained();
      while (pending_events.size() > 0 || req_tvalid || expected_status.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_multiplier(input logic [tmspg_pkg::MULT_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   logic [tmspg_pkg::MULT_WIDTH-1:0] phase_mult [6] = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd1, 8'd3};

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at the reset multiplier
      queue_event(OP_UNUSED, 1'b0);              // unused op only reports
      queue_event(tmspg_pkg::OP_TICK, 1'b1);     // tick while stopped
      queue_event(tmspg_pkg::OP_ENCODER, 1'b0);  // counterclockwise wrap to stop entry
      queue_event(tmspg_pkg::OP_BUTTON, 1'b0);   // stop while stopped
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);  // clockwise wrap back to zero
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);
      queue_event(tmspg_pkg::OP_BUTTON, 1'b1);   // select pattern one
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);
      queue_event(tmspg_pkg::OP_BUTTON, 1'b0);   // select pattern two
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);
      queue_event(tmspg_pkg::OP_BUTTON, 1'b0);   // start
      repeat (3) queue_event(tmspg_pkg::OP_TICK, 1'b0);
      queue_event(tmspg_pkg::OP_ENCODER, 1'b0);
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);
      queue_event(tmspg_pkg::OP_BUTTON, 1'b1);   // stop
      queue_event(tmspg_pkg::OP_ENCODER, 1'b1);
      queue_event(tmspg_pkg::OP_BUTTON, 1'b0);   // back to pattern zero
      queue_event(OP_UNUSED, 1'b1);
      queue_event(tmspg_pkg::OP_TICK, 1'b1);
      wait_until_drained();

      // random phases, each after writing its multiplier, extremes included
      foreach (phase_mult[i]) begin
         write_multiplier(phase_mult[i]);
         queue_random_events(PHASE_ITEMS);
         wait_until_drained();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
